// ===== sv/rti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_pkg
// shared constants for the ray/triangle intersection pipeline
// ----------------------------------------------------------------------------
package rti_pkg;

    // configuration register indexes
    localparam logic REG_DET_EPSILON  = 1'b0;
    localparam logic REG_MIN_DISTANCE = 1'b1;

    localparam int CFG_DATA_W = 32;
    localparam int EPS_W      = 32;
    localparam int DIST_W     = 32;
    localparam int LIM_W      = 31;

    // quotient bits produced by the divider and fraction bits of t
    localparam int Q_BITS = 31;
    localparam int T_FRAC = 16;

    localparam logic [EPS_W-1:0]  DET_EPS_RESET = 32'd1;
    localparam logic [LIM_W-1:0]  MIN_DIST_RESET = 31'd1;
    localparam logic [DIST_W-1:0] DIST_SAT      = 32'h7FFF_FFFF;

endpackage

// ===== sv/ray_triangle_intersect.sv =====
`timescale 1ns / 1ps
// throughput: one test per cycle; the whole pipeline halts while the output
//   word waits, so s_tready follows m_tready whenever a result is held
// the 31 quotient bits of t come from one restoring divide stage per bit
// reset: synchronous, active low; clears every valid bit and loads the
//   register defaults (det_epsilon = 1, min_distance = 1)
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// moller-trumbore ray/triangle test, exact integer arithmetic, pipelined
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
    parameter int COORD_WIDTH = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // ray_origin, ray_direction, vertex_a, vertex_b, vertex_c (low to high)
    input  logic [((5*3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // hit_distance
    output logic [31:0]            m_tdata,
    // is_hit
    output logic                   m_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_addr,
    input  logic [rti_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int VEC_W = 3 * CW;
    localparam int CW2   = CW + 1;           // differences
    localparam int XW    = 2 * CW2 + 1;      // cross product terms
    localparam int LB    = CW2 + 1;          // low slice of a cross term
    localparam int HB    = XW - LB;
    localparam int PW    = CW2 + XW;         // one dot product term
    localparam int DW    = 3 * CW2 + 3;      // dot product sums
    localparam int QB    = rti_pkg::Q_BITS;
    localparam int TF    = rti_pkg::T_FRAC;
    localparam int NSH   = QB - TF;          // numerator bits held above the divider

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- configuration
    logic [rti_pkg::EPS_W-1:0] eps_reg;
    logic [rti_pkg::LIM_W-1:0] lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= rti_pkg::DET_EPS_RESET;
            lim_reg <= rti_pkg::MIN_DIST_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rti_pkg::REG_DET_EPSILON:  eps_reg <= cfg_wdata[rti_pkg::EPS_W-1:0];
                rti_pkg::REG_MIN_DISTANCE: lim_reg <= cfg_wdata[rti_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: unpack and edge vectors
    logic signed [CW2-1:0] ext [5][3];

    always_comb begin
        for (int f = 0; f < 5; f++) begin
            for (int k = 0; k < 3; k++) begin
                ext[f][k] = CW2'($signed(s_tdata[f*VEC_W + k*CW +: CW]));
            end
        end
    end

    logic                  v1_reg;
    logic signed [CW2-1:0] e1_1_reg [3], e2_1_reg [3], s_1_reg [3], d_1_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                e1_1_reg[k] <= ext[3][k] - ext[2][k];
                e2_1_reg[k] <= ext[4][k] - ext[2][k];
                s_1_reg[k]  <= ext[0][k] - ext[2][k];
                d_1_reg[k]  <= ext[1][k];
            end
        end
    end

    // ---------------- stage 2: cross product terms
    logic                      v2_reg;
    logic signed [2*CW2-1:0]   hp_reg [3][2], qp_reg [3][2];
    logic signed [CW2-1:0]     e1_2_reg [3], e2_2_reg [3], s_2_reg [3], d_2_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                hp_reg[k][0] <= d_1_reg[(k+1)%3] * e2_1_reg[(k+2)%3];
                hp_reg[k][1] <= d_1_reg[(k+2)%3] * e2_1_reg[(k+1)%3];
                qp_reg[k][0] <= s_1_reg[(k+1)%3] * e1_1_reg[(k+2)%3];
                qp_reg[k][1] <= s_1_reg[(k+2)%3] * e1_1_reg[(k+1)%3];
                e1_2_reg[k]  <= e1_1_reg[k];
                e2_2_reg[k]  <= e2_1_reg[k];
                s_2_reg[k]   <= s_1_reg[k];
                d_2_reg[k]   <= d_1_reg[k];
            end
        end
    end

    // ---------------- stage 3: h = d x e2, q = s x e1
    logic                  v3_reg;
    logic signed [XW-1:0]  h_reg [3], q_reg [3];
    logic signed [CW2-1:0] e1_3_reg [3], e2_3_reg [3], s_3_reg [3], d_3_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                h_reg[k]    <= XW'(hp_reg[k][0]) - XW'(hp_reg[k][1]);
                q_reg[k]    <= XW'(qp_reg[k][0]) - XW'(qp_reg[k][1]);
                e1_3_reg[k] <= e1_2_reg[k];
                e2_3_reg[k] <= e2_2_reg[k];
                s_3_reg[k]  <= s_2_reg[k];
                d_3_reg[k]  <= d_2_reg[k];
            end
        end
    end

    // ---------------- stage 4: dot product partial products
    // dot j: 0 det = e1.h, 1 nu = s.h, 2 nv = d.q, 3 nt = e2.q
    logic signed [CW2-1:0] dot_a [4][3];
    logic signed [XW-1:0]  dot_x [4][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dot_a[0][k] = e1_3_reg[k];  dot_x[0][k] = h_reg[k];
            dot_a[1][k] = s_3_reg[k];   dot_x[1][k] = h_reg[k];
            dot_a[2][k] = d_3_reg[k];   dot_x[2][k] = q_reg[k];
            dot_a[3][k] = e2_3_reg[k];  dot_x[3][k] = q_reg[k];
        end
    end

    logic                       v4_reg;
    logic signed [CW2+LB:0]     pl_reg [4][3];
    logic signed [CW2+HB-1:0]   ph_reg [4][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 3; k++) begin
                    pl_reg[j][k] <= dot_a[j][k] * $signed({1'b0, dot_x[j][k][LB-1:0]});
                    ph_reg[j][k] <= dot_a[j][k] * $signed(dot_x[j][k][XW-1:LB]);
                end
            end
        end
    end

    // ---------------- stage 5: recombine partial products
    logic                 v5_reg;
    logic signed [PW-1:0] pr_reg [4][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (adv) v5_reg <= v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 3; k++) begin
                    pr_reg[j][k] <= (PW'(ph_reg[j][k]) <<< LB) + PW'(pl_reg[j][k]);
                end
            end
        end
    end

    // ---------------- stage 6: dot product sums
    logic                 v6_reg;
    logic signed [DW-1:0] sum_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (adv) v6_reg <= v5_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                sum_reg[j] <= DW'(pr_reg[j][0]) + DW'(pr_reg[j][1]) + DW'(pr_reg[j][2]);
            end
        end
    end

    // ---------------- stage 7: make det positive
    logic                 v7_reg;
    logic signed [DW-1:0] nrm_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) v7_reg <= 1'b0;
        else if (adv) v7_reg <= v6_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                nrm_reg[j] <= sum_reg[0][DW-1] ? -sum_reg[j] : sum_reg[j];
            end
        end
    end

    // ---------------- stage 8: reject tests, divider set-up
    logic signed [DW-1:0] det_c, nu_c, nv_c, nt_c;
    logic signed [DW:0]   uv_c;
    logic [DW-1:0]        nt_top_c;
    logic                 miss_c, ovf_c;

    always_comb begin
        det_c    = nrm_reg[0];
        nu_c     = nrm_reg[1];
        nv_c     = nrm_reg[2];
        nt_c     = nrm_reg[3];
        uv_c     = (DW+1)'(nu_c) + (DW+1)'(nv_c);
        nt_top_c = DW'(nt_c >>> NSH);
        miss_c   = (det_c == '0) || (det_c < $signed({1'b0, DW'(eps_reg)}))
                || nu_c[DW-1] || (nu_c > det_c)
                || nv_c[DW-1] || (uv_c > (DW+1)'(det_c))
                || nt_c[DW-1] || (nt_c == '0);
        // t would not fit in the quotient width
        ovf_c    = nt_top_c >= DW'(det_c);
    end

    logic [QB:0]       dv_reg;
    logic [DW-1:0]     dd_reg  [QB+1];
    logic [DW-1:0]     dr_reg  [QB+1];
    logic [NSH-1:0]    dn_reg  [QB+1];
    logic [QB-1:0]     dq_reg  [QB+1];
    logic [QB:0]       dm_reg;
    logic [QB:0]       do_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) dv_reg[0] <= 1'b0;
        else if (adv) dv_reg[0] <= v7_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dd_reg[0] <= DW'(det_c);
            dr_reg[0] <= nt_top_c;
            dn_reg[0] <= nt_c[NSH-1:0];
            dq_reg[0] <= '0;
            dm_reg[0] <= miss_c;
            do_reg[0] <= ovf_c;
        end
    end

    // ---------------- stages 9 to 39: restoring divide, one quotient bit each
    for (genvar i = 0; i < QB; i++) begin : g_div
        localparam int B = QB - 1 - i;
        logic [DW:0]   sh_c;
        logic [DW:0]   df_c;
        logic          ge_c;

        always_comb begin
            if (B >= TF) sh_c = {dr_reg[i], dn_reg[i][NSH-1]};
            else         sh_c = {dr_reg[i], 1'b0};
            df_c = sh_c - {1'b0, dd_reg[i]};
            ge_c = sh_c >= {1'b0, dd_reg[i]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) dv_reg[i+1] <= 1'b0;
            else if (adv) dv_reg[i+1] <= dv_reg[i];
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dd_reg[i+1] <= dd_reg[i];
                dr_reg[i+1] <= ge_c ? df_c[DW-1:0] : sh_c[DW-1:0];
                dn_reg[i+1] <= dn_reg[i] << 1;
                dq_reg[i+1] <= dq_reg[i] | (QB'(ge_c) << B);
                dm_reg[i+1] <= dm_reg[i];
                do_reg[i+1] <= do_reg[i];
            end
        end
    end

    // ---------------- stage 40: output word
    logic        hit_c;
    logic        out_valid_reg;
    logic        out_hit_reg;
    logic [31:0] out_dist_reg;

    assign hit_c = !dm_reg[QB] && (do_reg[QB] || (dq_reg[QB] > lim_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (adv) out_valid_reg <= dv_reg[QB];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_hit_reg <= hit_c;
            if (!hit_c)          out_dist_reg <= '0;
            else if (do_reg[QB]) out_dist_reg <= rti_pkg::DIST_SAT;
            else                 out_dist_reg <= rti_pkg::DIST_W'(dq_reg[QB]);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = out_dist_reg;

endmodule

// ===== sv/rti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_checker
// port-level checks on the intersection pipeline's result channel
// ----------------------------------------------------------------------------
module rti_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // a held word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a stalled output halts the input side
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // a miss carries zero distance
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0)
        else $error("miss with nonzero distance");

    // a hit lies strictly in front and never goes negative
    a_hit_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tdata[31] && m_tdata != 32'd0)
        else $error("hit with bad distance");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/ray_triangle_intersect_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_check
// watches the input, result and register ports of the intersection block,
// works out each expected hit and distance and compares the result words
// ----------------------------------------------------------------------------
module ray_triangle_intersect_check (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [303:0] s_tdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  m_tdata,
    input  logic         m_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_wdata,
    output int           errors,
    output int           outstanding
);

    typedef logic signed [127:0] wide_t;
    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
    } hit_t;

    hit_t pending_hits[$];
    logic [rti_pkg::EPS_W-1:0] det_eps;
    logic [rti_pkg::LIM_W-1:0] min_dist;

    function automatic longint crd(logic [59:0] v, int i);
        logic signed [19:0] raw;
        raw = v[i*20 +: 20];
        return longint'(raw);
    endfunction

    function automatic hit_t intersect_ray(logic [303:0] w);
        longint o[3], d[3], a[3], b[3], c[3], e1[3], e2[3], s[3], h[3], q[3];
        wide_t det, nu, nv, nt;
        logic [127:0] quot;
        hit_t r;
        for (int i = 0; i < 3; i++) begin
            o[i] = crd(w[59:0], i);
            d[i] = crd(w[119:60], i);
            a[i] = crd(w[179:120], i);
            b[i] = crd(w[239:180], i);
            c[i] = crd(w[299:240], i);
            e1[i] = b[i] - a[i];
            e2[i] = c[i] - a[i];
            s[i] = o[i] - a[i];
        end
        h[0] = d[1]*e2[2] - d[2]*e2[1];
        h[1] = d[2]*e2[0] - d[0]*e2[2];
        h[2] = d[0]*e2[1] - d[1]*e2[0];
        q[0] = s[1]*e1[2] - s[2]*e1[1];
        q[1] = s[2]*e1[0] - s[0]*e1[2];
        q[2] = s[0]*e1[1] - s[1]*e1[0];
        det = wide_t'(e1[0])*wide_t'(h[0]) + wide_t'(e1[1])*wide_t'(h[1])
            + wide_t'(e1[2])*wide_t'(h[2]);
        nu = wide_t'(s[0])*wide_t'(h[0]) + wide_t'(s[1])*wide_t'(h[1])
            + wide_t'(s[2])*wide_t'(h[2]);
        nv = wide_t'(d[0])*wide_t'(q[0]) + wide_t'(d[1])*wide_t'(q[1])
            + wide_t'(d[2])*wide_t'(q[2]);
        nt = wide_t'(e2[0])*wide_t'(q[0]) + wide_t'(e2[1])*wide_t'(q[1])
            + wide_t'(e2[2])*wide_t'(q[2]);
        r = '0;
        if (det < 0) begin
            det = -det;
            nu = -nu;
            nv = -nv;
            nt = -nt;
        end
        // zero determinant is parallel even with a zero band
        if (det == 0 || det < wide_t'({96'd0, det_eps})) return r;
        if (nu < 0 || nu > det) return r;
        if (nv < 0 || nu + nv > det) return r;
        if (nt <= 0) return r;
        quot = unsigned'(nt <<< rti_pkg::T_FRAC) / unsigned'(det);
        // hit test on the truncated value before saturation
        if (quot <= {97'd0, min_dist}) return r;
        r.hit = 1'b1;
        r.distance = (quot > 128'h7FFF_FFFF) ? rti_pkg::DIST_SAT : quot[31:0];
        return r;
    endfunction

    initial begin
        errors = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        hit_t exp_w;
        if (!aresetn) begin
            det_eps <= rti_pkg::DET_EPS_RESET;
            min_dist <= rti_pkg::MIN_DIST_RESET;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == rti_pkg::REG_DET_EPSILON) det_eps <= cfg_wdata;
                else min_dist <= cfg_wdata[rti_pkg::LIM_W-1:0];
            end
            if (s_tvalid && s_tready) pending_hits.push_back(intersect_ray(s_tdata));
            if (m_tvalid && m_tready) begin
                if (pending_hits.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    exp_w = pending_hits.pop_front();
                    if (m_tuser !== exp_w.hit) begin
                        $error("is_hit: expected %0d, got %0d", exp_w.hit, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== exp_w.distance) begin
                        $error("hit_distance: expected %h, got %h", exp_w.distance, m_tdata);
                        errors++;
                    end
                end
            end
            outstanding = pending_hits.size();
        end
    end

endmodule

// ===== tb/sv/ray_triangle_intersect_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_test
// drives directed, aimed random and noise rays into the intersection block under
// several register settings, with random stalls on both ports
// ----------------------------------------------------------------------------
module ray_triangle_intersect_test;

    localparam int WATCHDOG = 3000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [303:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_addr = rti_pkg::REG_DET_EPSILON;
    logic [31:0]  cfg_wdata = '0;

    int  errors, outstanding, quiet_cycles;
    bit  quiet = 0, hold_req = 0;
    int  hold_left = 0, idle_left = 0;

    ray_triangle_intersect dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    ray_triangle_intersect_check chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .errors(errors), .outstanding(outstanding)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side stalls
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left <= 300;
            m_tready <= 1'b0;
        end else if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            idle_left <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [59:0] pack3(longint x, longint y, longint z);
        logic [19:0] px, py, pz;
        px = x[19:0];
        py = y[19:0];
        pz = z[19:0];
        return {pz, py, px};
    endfunction

    function automatic logic [303:0] ray_word(logic [59:0] o, logic [59:0] d,
                                              logic [59:0] a, logic [59:0] b,
                                              logic [59:0] c);
        return {4'd0, c, b, a, d, o};
    endfunction

    function automatic longint srand(int m);
        return longint'($urandom_range(0, 2*m)) - m;
    endfunction

    // ray aimed at a point picked inside or near the triangle
    function automatic logic [303:0] aimed_ray();
        longint a[3], b[3], c[3], o[3], p[3], d[3];
        int u, v, sc;
        u = $urandom_range(0, 300);
        v = $urandom_range(0, 300);
        sc = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            a[i] = srand(4096);
            b[i] = srand(4096);
            c[i] = ($urandom_range(0, 9) == 0) ? a[i] + 2*(b[i] - a[i]) : srand(4096);
            o[i] = srand(8192);
            p[i] = a[i] + ((b[i] - a[i])*u + (c[i] - a[i])*v) / 256;
            d[i] = p[i] - o[i];
            if (sc == 0) d[i] = d[i] / 512;
            else if (sc == 1) d[i] = -d[i];
            else if (sc < 4) d[i] = d[i] * 2;
        end
        return ray_word(pack3(o[0], o[1], o[2]), pack3(d[0], d[1], d[2]),
                        pack3(a[0], a[1], a[2]), pack3(b[0], b[1], b[2]),
                        pack3(c[0], c[1], c[2]));
    endfunction

    function automatic logic [303:0] noise_ray();
        logic [303:0] w;
        logic [31:0]  top;
        for (int i = 0; i < 9; i++) w[i*32 +: 32] = $urandom;
        top = $urandom;
        w[303:288] = top[15:0];
        w[303:300] = 4'd0;
        return w;
    endfunction

    task automatic send_word(logic [303:0] w);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        s_tvalid <= 1'b0;
        // let the checker count the last accepted word as outstanding first
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_directed();
        logic [59:0] one_z, tri_a, tri_b, tri_c;
        tri_a = pack3(0, 0, 0);
        tri_b = pack3(1024, 0, 0);
        tri_c = pack3(0, 1024, 0);
        one_z = pack3(0, 0, 1024);
        send_word('0);
        send_word({4'd0, {300{1'b1}}});
        send_word(ray_word(pack3(524287, 524287, 524287), pack3(-524288, -524288, -524288),
                           pack3(-524288, 524287, -524288), pack3(524287, -524288, 524287),
                           pack3(524287, 524287, -524288)));
        // clean hit, then vertex, edge and outside cases
        send_word(ray_word(pack3(256, 256, -1024), one_z, tri_a, tri_b, tri_c));
        send_word(ray_word(pack3(0, 0, -1024), one_z, tri_a, tri_b, tri_c));
        send_word(ray_word(pack3(512, 512, -1024), one_z, tri_a, tri_b, tri_c));
        send_word(ray_word(pack3(-10, 256, -1024), one_z, tri_a, tri_b, tri_c));
        send_word(ray_word(pack3(256, -10, -1024), one_z, tri_a, tri_b, tri_c));
        send_word(ray_word(pack3(600, 600, -1024), one_z, tri_a, tri_b, tri_c));
        // parallel ray and flat triangle give zero determinant
        send_word(ray_word(pack3(256, 256, -1024), pack3(1024, 0, 0), tri_a, tri_b, tri_c));
        send_word(ray_word(pack3(256, 256, -1024), one_z, tri_a, tri_b, pack3(2048, 0, 0)));
        // triangle behind the origin, and origin on the plane
        send_word(ray_word(pack3(256, 256, 1024), one_z, tri_a, tri_b, tri_c));
        send_word(ray_word(pack3(256, 256, 0), one_z, tri_a, tri_b, tri_c));
        // tiny direction gives large t, near-zero t below the minimum
        send_word(ray_word(pack3(256, 256, -524288), pack3(0, 0, 1), tri_a, tri_b, tri_c));
        send_word(ray_word(pack3(256, 256, -1024), pack3(0, 0, 1), tri_a, tri_b, tri_c));
        send_word(ray_word(pack3(256, 256, -1), pack3(0, 0, 524287), tri_a, tri_b, tri_c));
        // reversed winding flips the sign of the determinant
        send_word(ray_word(pack3(256, 256, -1024), one_z, tri_a, tri_c, tri_b));
        send_word(ray_word(pack3(256, 256, 1024), pack3(0, 0, -1024), tri_a, tri_c, tri_b));
    endtask

    initial begin
        logic [31:0] eps_set[6];
        logic [31:0] lim_set[6];
        eps_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 32'd1};
        lim_set = '{32'd0, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0, 32'd1};
        eps_set[3] = $urandom_range(0, 1 << 20);
        lim_set[3] = $urandom_range(0, 1 << 18);
        eps_set[4] = $urandom;
        lim_set[4] = $urandom & 32'h7FFF_FFFF;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_directed();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(rti_pkg::REG_DET_EPSILON, eps_set[ph]);
            write_reg(rti_pkg::REG_MIN_DISTANCE, lim_set[ph]);
            if (ph == 1) hold_req = 1;
            if (ph == 5) quiet = 1;
            if (ph == 0) send_directed();
            repeat (150) begin
                if ($urandom_range(0, 9) < 7) send_word(aimed_ray());
                else send_word(noise_ray());
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
